@@ rtl/gfdr_pkg.sv @@
// Shared types and constants of the gap-framed datagram receiver.
package gfdr_pkg;

   localparam int BYTE_W     = 8;
   localparam int ADDR_W     = 64;
   localparam int PLEN_W     = 11;
   localparam int STATUS_W   = 3;
   localparam int REQ_DATA_W = 8;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 88;

   // Bit positions of the request tuser flags
   localparam int REQ_USER_GAP = 0;
   localparam int REQ_USER_ERR = 1;

   // Result kinds
   localparam logic KIND_PAYLOAD   = 1'b0;
   localparam logic KIND_FRAME_END = 1'b1;

   // Frame-end status codes
   localparam logic [STATUS_W-1:0] ST_ACCEPT     = 3'd0;
   localparam logic [STATUS_W-1:0] ST_MISMATCH   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_LINE_ERROR = 3'd2;
   localparam logic [STATUS_W-1:0] ST_TRUNCATED  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_TOO_LONG   = 3'd4;

   typedef struct packed {
      logic                kind;
      logic [BYTE_W-1:0]   payload_byte;
      logic [PLEN_W-1:0]   payload_length;
      logic [ADDR_W-1:0]   source_address;
      logic [STATUS_W-1:0] status;
   } result_type;

endpackage

@@ rtl/gap_framed_datagram_receiver_core.sv @@
// Top level of the gap-framed datagram receiver with address filtering.
//
// The req channel carries receive events from a UART: tdata is the byte,
// tuser[0] marks an inter-frame gap and tuser[1] a line error on the byte.
// A frame is ADDRESS_BYTES source bytes, ADDRESS_BYTES destination bytes,
// then payload bytes until a gap. Each payload byte leaves on the rsp
// channel at once (tuser = 0); every started frame ends in one frame-end
// beat (tuser = 1) with source address, payload length and status.
// The csr channel writes the own address and is always ready. The user
// writes it only while no beat is in flight, possibly inside an open
// frame; the block does not enforce this. Results reach rsp registered,
// in the cycle after their req beat. Throughput: one req beat per cycle;
// the frame state update and the result register sit behind one short
// level of logic. When rsp stalls with a result held, req_tready drops
// until rsp moves; if rsp is taken in the same cycle, a new beat is
// taken as well. Reset clears the frame state to idle, the own address
// to zero and empties the result register.
module gap_framed_datagram_receiver_core #(
   parameter int ADDRESS_BYTES = 8,
   parameter int MAX_PAYLOAD   = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   // req: action (tuser[0]), line_error (tuser[1])
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [gfdr_pkg::REQ_DATA_W-1:0]     req_tdata,   // rx_byte [7:0]
   input  logic [gfdr_pkg::REQ_USER_W-1:0]     req_tuser,   // action [0], line_error [1]
   // rsp: payload_byte [7:0], payload_length [18:8], source_address [82:19],
   //      status [85:83], zero [87:86]
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [gfdr_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tuser,   // kind [0]
   // csr: own_address
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [gfdr_pkg::ADDR_W-1:0]         csr_data
);

   localparam int PadW = gfdr_pkg::RSP_DATA_W - gfdr_pkg::BYTE_W - gfdr_pkg::PLEN_W
                         - gfdr_pkg::ADDR_W - gfdr_pkg::STATUS_W;

   logic [gfdr_pkg::ADDR_W-1:0]     own_address_ff;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [gfdr_pkg::RSP_DATA_W-1:0] rsp_data_ff;
   logic                            rsp_kind_ff;
   logic                            step;
   logic                            res_valid;
   gfdr_pkg::result_type            res;

   assign csr_ready  = 1'b1;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign step       = req_tvalid && req_tready;

   gfdr_parser #(
      .ADDRESS_BYTES (ADDRESS_BYTES),
      .MAX_PAYLOAD   (MAX_PAYLOAD)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .gap         (req_tuser[gfdr_pkg::REQ_USER_GAP]),
      .rx_byte     (req_tdata),
      .line_error  (req_tuser[gfdr_pkg::REQ_USER_ERR]),
      .own_address (own_address_ff),
      .res_valid   (res_valid),
      .res         (res)
   );

   // Hold the own address
   always_ff @(posedge clock) begin
      if (reset) begin
         own_address_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         own_address_ff <= csr_data;
      end
   end

   // Load a new result on an accepted beat, drop it once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (step) begin
         rsp_valid_in = res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_data_ff <= {{PadW{1'b0}}, res.status, res.source_address,
                         res.payload_length, res.payload_byte};
         rsp_kind_ff <= res.kind;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;

endmodule

@@ rtl/gfdr_parser.sv @@
// Frame parser: header capture, address filter, payload count and verdict.
module gfdr_parser #(
   parameter int ADDRESS_BYTES = 8,
   parameter int MAX_PAYLOAD   = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic                          gap,
   input  logic [gfdr_pkg::BYTE_W-1:0]   rx_byte,
   input  logic                          line_error,
   input  logic [gfdr_pkg::ADDR_W-1:0]   own_address,
   output logic                          res_valid,
   output gfdr_pkg::result_type          res
);

   localparam int HidxW = (ADDRESS_BYTES > 1) ? $clog2(ADDRESS_BYTES) : 1;
   localparam int CntW  = $clog2(MAX_PAYLOAD + 1);
   localparam int LenW  = gfdr_pkg::PLEN_W;
   localparam logic [HidxW-1:0] HidxLast = HidxW'(ADDRESS_BYTES - 1);
   localparam logic [CntW-1:0]  CntMax   = CntW'(MAX_PAYLOAD);

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_SOURCE,
      PH_DEST,
      PH_PAYLOAD,
      PH_DISCARD
   } phase_type;

   phase_type                   phase_ff, phase_in;
   logic [HidxW-1:0]            hidx_ff, hidx_in;
   logic [gfdr_pkg::ADDR_W-1:0] sender_ff, sender_in;
   logic                        match_ff, match_in;
   logic [CntW-1:0]             count_ff, count_in;

   // Frame context as seen by a byte: a byte in idle opens a fresh frame
   phase_type                   phase_eff;
   logic [HidxW-1:0]            hidx_eff;
   logic [gfdr_pkg::ADDR_W-1:0] sender_eff;
   logic                        match_eff;
   logic [CntW-1:0]             count_eff;
   logic [HidxW+2:0]            bit_pos;

   always_comb begin
      if (phase_ff == PH_IDLE) begin
         phase_eff  = PH_SOURCE;
         hidx_eff   = '0;
         sender_eff = '0;
         match_eff  = 1'b1;
         count_eff  = '0;
      end else begin
         phase_eff  = phase_ff;
         hidx_eff   = hidx_ff;
         sender_eff = sender_ff;
         match_eff  = match_ff;
         count_eff  = count_ff;
      end
      bit_pos = {hidx_eff, 3'b000};
   end

   // Next state and result of one beat
   always_comb begin
      phase_in  = phase_ff;
      hidx_in   = hidx_ff;
      sender_in = sender_ff;
      match_in  = match_ff;
      count_in  = count_ff;
      res_valid = 1'b0;
      res       = '0;

      if (gap) begin
         // Close the frame on a gap
         phase_in                = PH_IDLE;
         res.kind                = gfdr_pkg::KIND_FRAME_END;
         res.payload_length      = LenW'(count_ff);
         res.source_address      = sender_ff;
         case (phase_ff)
            PH_SOURCE, PH_DEST: begin
               res_valid  = 1'b1;
               res.status = gfdr_pkg::ST_TRUNCATED;
            end
            PH_PAYLOAD: begin
               res_valid = 1'b1;
               if (own_address[7:0] == 8'h00 || match_ff) begin
                  res.status = gfdr_pkg::ST_ACCEPT;
               end else begin
                  res.status = gfdr_pkg::ST_MISMATCH;
               end
            end
            default: begin
               res_valid = 1'b0;
            end
         endcase
      end else if (phase_ff != PH_DISCARD) begin
         phase_in  = phase_eff;
         hidx_in   = hidx_eff;
         sender_in = sender_eff;
         match_in  = match_eff;
         count_in  = count_eff;
         if (line_error) begin
            // Report the line error at once, then drop until the gap
            phase_in           = PH_DISCARD;
            res_valid          = 1'b1;
            res.kind           = gfdr_pkg::KIND_FRAME_END;
            res.payload_length = LenW'(count_eff);
            res.source_address = sender_eff;
            res.status         = gfdr_pkg::ST_LINE_ERROR;
         end else begin
            case (phase_eff)
               PH_SOURCE: begin
                  sender_in[bit_pos +: 8] = sender_eff[bit_pos +: 8] | rx_byte;
                  hidx_in = hidx_eff + 1'b1;
                  if (hidx_eff == HidxLast) begin
                     hidx_in  = '0;
                     phase_in = PH_DEST;
                  end
               end
               PH_DEST: begin
                  if (own_address[bit_pos +: 8] != rx_byte) begin
                     match_in = 1'b0;
                  end
                  hidx_in = hidx_eff + 1'b1;
                  if (hidx_eff == HidxLast) begin
                     hidx_in  = '0;
                     phase_in = PH_PAYLOAD;
                  end
               end
               PH_PAYLOAD: begin
                  res_valid = 1'b1;
                  if (count_eff >= CntMax) begin
                     phase_in           = PH_DISCARD;
                     res.kind           = gfdr_pkg::KIND_FRAME_END;
                     res.payload_length = LenW'(count_eff);
                     res.source_address = sender_eff;
                     res.status         = gfdr_pkg::ST_TOO_LONG;
                  end else begin
                     count_in         = count_eff + 1'b1;
                     res.kind         = gfdr_pkg::KIND_PAYLOAD;
                     res.payload_byte = rx_byte;
                  end
               end
               default: begin
                  phase_in = phase_eff;
               end
            endcase
         end
      end
   end

   // Hold frame state; advance only on an accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         hidx_ff   <= '0;
         sender_ff <= '0;
         match_ff  <= 1'b1;
         count_ff  <= '0;
      end else if (step) begin
         phase_ff  <= phase_in;
         hidx_ff   <= hidx_in;
         sender_ff <= sender_in;
         match_ff  <= match_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ rtl/gfdr_checker.sv @@
// Port-level checks of the datagram receiver and their bind.
module gfdr_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [gfdr_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                            rsp_tuser
);

   // A held result keeps its beat
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp beat changed while stalled");

   // A stalled result blocks new request beats
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("req accepted while rsp stalled");

   // Payload beats carry no length, source or status
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[87:8] == '0)
      else $error("payload beat carries frame-end fields");

   // Frame-end status stays within its codes
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[87:86] == 2'b00
         && rsp_tdata[85:83] <= gfdr_pkg::ST_TOO_LONG)
      else $error("frame-end beat with bad status");

   // Reset empties the result register
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

endmodule

bind gap_framed_datagram_receiver_core gfdr_checker u_gfdr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

@@ tb/tb_gap_framed_datagram_receiver_core.sv @@
// Self-checking testbench for the gap-framed datagram receiver core.
module tb_gap_framed_datagram_receiver_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ADDR_BYTES  = 8;
   localparam int MAX_PAY     = 1024;
   localparam int PHASES      = 12;
   localparam int PHASE_BEATS = 18;
   localparam int LONG_HOLD   = 40;

   typedef enum logic [2:0] {
      PH_IDLE, PH_SOURCE, PH_DEST, PH_PAYLOAD, PH_DISCARD
   } rx_phase_type;

   // How the expected beat of one input beat is obtained
   typedef enum logic [1:0] {ROW_MODEL, ROW_NONE, ROW_END} row_check_type;

   typedef struct packed {
      logic                 gap;
      logic                 err;
      logic [7:0]           data;
      row_check_type        mode;
      gfdr_pkg::result_type want;
   } stim_event_type;

   localparam gfdr_pkg::result_type NO_BEAT = '0;

   // Directed rows; the own address is still at its reset value of zero
   localparam stim_event_type DIRECTED [21] = '{
      '{1'b1, 1'b0, 8'h00, ROW_NONE, NO_BEAT},
      '{1'b0, 1'b1, 8'h00, ROW_END,
        '{gfdr_pkg::KIND_FRAME_END, 8'h00, 11'd0, 64'h0, gfdr_pkg::ST_LINE_ERROR}},
      '{1'b0, 1'b1, 8'hFF, ROW_NONE, NO_BEAT},
      '{1'b0, 1'b0, 8'h5A, ROW_NONE, NO_BEAT},
      '{1'b1, 1'b1, 8'hA5, ROW_NONE, NO_BEAT},
      '{1'b1, 1'b0, 8'hFF, ROW_NONE, NO_BEAT},
      '{1'b0, 1'b0, 8'hFF, ROW_MODEL, NO_BEAT},
      '{1'b0, 1'b0, 8'h00, ROW_MODEL, NO_BEAT},
      '{1'b0, 1'b0, 8'h81, ROW_MODEL, NO_BEAT},
      '{1'b1, 1'b0, 8'h00, ROW_END,
        '{gfdr_pkg::KIND_FRAME_END, 8'h00, 11'd0, 64'h0000_0000_0081_00FF,
          gfdr_pkg::ST_TRUNCATED}},
      '{1'b0, 1'b0, 8'h01, ROW_MODEL, NO_BEAT},
      '{1'b0, 1'b0, 8'h02, ROW_MODEL, NO_BEAT},
      '{1'b0, 1'b0, 8'h03, ROW_MODEL, NO_BEAT},
      '{1'b0, 1'b0, 8'h04, ROW_MODEL, NO_BEAT},
      '{1'b0, 1'b0, 8'h05, ROW_MODEL, NO_BEAT},
      '{1'b0, 1'b0, 8'h06, ROW_MODEL, NO_BEAT},
      '{1'b0, 1'b0, 8'h07, ROW_MODEL, NO_BEAT},
      '{1'b0, 1'b0, 8'h08, ROW_MODEL, NO_BEAT},
      '{1'b0, 1'b0, 8'h00, ROW_MODEL, NO_BEAT},
      '{1'b0, 1'b1, 8'h7E, ROW_END,
        '{gfdr_pkg::KIND_FRAME_END, 8'h00, 11'd0, 64'h0807_0605_0403_0201,
          gfdr_pkg::ST_LINE_ERROR}},
      '{1'b1, 1'b0, 8'h00, ROW_NONE, NO_BEAT}
   };

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_tvalid;
   logic                            req_tready;
   logic [gfdr_pkg::REQ_DATA_W-1:0] req_tdata;
   logic [gfdr_pkg::REQ_USER_W-1:0] req_tuser;
   logic                            rsp_tvalid;
   logic                            rsp_tready;
   logic [gfdr_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                            rsp_tuser;
   logic                            csr_valid;
   logic                            csr_ready;
   logic [gfdr_pkg::ADDR_W-1:0]     csr_data;

   // Predictor state
   logic [gfdr_pkg::ADDR_W-1:0] own_addr = '0;
   rx_phase_type                rx_phase = PH_IDLE;
   int                          hdr_idx = 0;
   logic [gfdr_pkg::ADDR_W-1:0] src_store = '0;
   logic                        dest_ok = 1'b1;
   int                          pay_count = 0;

   gfdr_pkg::result_type due_beats[$];
   stim_event_type       drv_ev;
   int                   mismatches = 0;
   int                   events_sent = 0;
   bit                   sender_quiet = 1'b0;
   bit                   rsp_quiet = 1'b0;
   int                   hold_off = 0;

   gap_framed_datagram_receiver_core #(
      .ADDRESS_BYTES(ADDR_BYTES),
      .MAX_PAYLOAD  (MAX_PAY)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #10 clock = ~clock;

   // Build the frame-end beat from the current frame state
   function automatic gfdr_pkg::result_type frame_end(
      input logic [gfdr_pkg::STATUS_W-1:0] status);
      gfdr_pkg::result_type beat;
      beat                = NO_BEAT;
      beat.kind           = gfdr_pkg::KIND_FRAME_END;
      beat.payload_length = pay_count[gfdr_pkg::PLEN_W-1:0];
      beat.source_address = src_store;
      beat.status         = status;
      return beat;
   endfunction

   // Advance the deframer by one receive event; return 1 when it emits a beat
   function automatic logic deframe(input logic gap, input logic err,
                                    input logic [7:0] b,
                                    output gfdr_pkg::result_type beat);
      rx_phase_type was;
      beat = NO_BEAT;
      if (gap) begin
         was      = rx_phase;
         rx_phase = PH_IDLE;
         if (was == PH_SOURCE || was == PH_DEST) begin
            beat = frame_end(gfdr_pkg::ST_TRUNCATED);
            return 1'b1;
         end
         if (was == PH_PAYLOAD) begin
            // wildcard when the own address starts with a zero byte
            beat = frame_end((own_addr[7:0] == 8'h00 || dest_ok) ?
                             gfdr_pkg::ST_ACCEPT : gfdr_pkg::ST_MISMATCH);
            return 1'b1;
         end
         return 1'b0;
      end
      if (rx_phase == PH_DISCARD)
         return 1'b0;
      if (rx_phase == PH_IDLE) begin
         hdr_idx   = 0;
         src_store = '0;
         dest_ok   = 1'b1;
         pay_count = 0;
         rx_phase  = PH_SOURCE;
      end
      if (err) begin
         rx_phase = PH_DISCARD;
         beat     = frame_end(gfdr_pkg::ST_LINE_ERROR);
         return 1'b1;
      end
      case (rx_phase)
         PH_SOURCE: begin
            src_store[hdr_idx*8 +: 8] = b;
            hdr_idx++;
            if (hdr_idx >= ADDR_BYTES) begin
               hdr_idx  = 0;
               rx_phase = PH_DEST;
            end
         end
         PH_DEST: begin
            if (own_addr[hdr_idx*8 +: 8] != b)
               dest_ok = 1'b0;
            hdr_idx++;
            if (hdr_idx >= ADDR_BYTES) begin
               hdr_idx  = 0;
               rx_phase = PH_PAYLOAD;
            end
         end
         default: begin
            if (pay_count >= MAX_PAY) begin
               rx_phase = PH_DISCARD;
               beat     = frame_end(gfdr_pkg::ST_TOO_LONG);
               return 1'b1;
            end
            pay_count++;
            beat.kind         = gfdr_pkg::KIND_PAYLOAD;
            beat.payload_byte = b;
            return 1'b1;
         end
      endcase
      return 1'b0;
   endfunction

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatches++;
      end
   endtask

   // Predict on each accepted req beat, check each accepted rsp beat
   always @(posedge clock) begin : scoreboard
      gfdr_pkg::result_type want;
      gfdr_pkg::result_type got;
      logic                 emits;
      if (!reset) begin
         if (csr_valid && csr_ready)
            own_addr = csr_data;
         if (req_tvalid && req_tready) begin
            emits = deframe(req_tuser[gfdr_pkg::REQ_USER_GAP],
                            req_tuser[gfdr_pkg::REQ_USER_ERR], req_tdata, want);
            case (drv_ev.mode)
               ROW_MODEL: if (emits) due_beats.push_back(want);
               ROW_END:   due_beats.push_back(drv_ev.want);
               default:   ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got.kind           = rsp_tuser;
            got.payload_byte   = rsp_tdata[7:0];
            got.payload_length = rsp_tdata[18:8];
            got.source_address = rsp_tdata[82:19];
            got.status         = rsp_tdata[85:83];
            if (due_beats.size() == 0) begin
               $error("unexpected rsp beat: kind %0b data %0h", rsp_tuser, rsp_tdata);
               mismatches++;
            end else begin
               want = due_beats.pop_front();
               check_field("kind", want.kind, got.kind);
               check_field("payload_byte", want.payload_byte, got.payload_byte);
               check_field("payload_length", want.payload_length, got.payload_length);
               check_field("source_address", want.source_address, got.source_address);
               check_field("status", want.status, got.status);
            end
         end
      end
   end

   // Receiver: random stall per beat, plus one long hold-off on request
   initial begin : rsp_side
      int n;
      rsp_tready = 1'b0;
      wait (reset == 1'b0);
      forever begin
         if (hold_off > 0) begin
            n        = hold_off;
            hold_off = 0;
         end else begin
            n = rsp_quiet ? 0 : $urandom_range(0, 6);
         end
         repeat (n) @(negedge clock) rsp_tready <= 1'b0;
         @(negedge clock) rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
      end
   end

   function automatic stim_event_type live_event(input logic gap, input logic err,
                                                 input logic [7:0] data);
      stim_event_type ev;
      ev.gap  = gap;
      ev.err  = err;
      ev.data = data;
      ev.mode = ROW_MODEL;
      ev.want = NO_BEAT;
      return ev;
   endfunction

   // Offer one req beat after a random gap and hold it until accepted
   task automatic send_event(input stim_event_type ev);
      int                              n;
      logic [gfdr_pkg::REQ_USER_W-1:0] user;
      n                            = sender_quiet ? 0 : $urandom_range(0, 6);
      user                         = '0;
      user[gfdr_pkg::REQ_USER_GAP] = ev.gap;
      user[gfdr_pkg::REQ_USER_ERR] = ev.err;
      repeat (n) @(negedge clock) req_tvalid <= 1'b0;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= ev.data;
      req_tuser  <= user;
      drv_ev     <= ev;
      do @(posedge clock); while (req_tready !== 1'b1);
      events_sent++;
   endtask

   task automatic send_gap();
      send_event(live_event(1'b1, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255))));
   endtask

   // Drop valid and wait until every expected beat has come back
   task automatic drain();
      @(negedge clock) req_tvalid <= 1'b0;
      while (due_beats.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_own_address(input logic [gfdr_pkg::ADDR_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      @(negedge clock) csr_valid <= 1'b0;
   endtask

   // Send one frame: source, destination, payload; optionally break it with a
   // line error at err_at, cut it at cut_at, and close it with a gap
   task automatic play_frame(input int plen, input int err_at, input int cut_at,
                             input bit close);
      logic [gfdr_pkg::ADDR_W-1:0] dest;
      logic [7:0]                  b;
      int                          r;
      r = $urandom_range(0, 99);
      if (r < 60)
         dest = own_addr;
      else if (r < 80)
         dest = own_addr ^ (64'($urandom_range(1, 255)) << (8 * $urandom_range(0, 7)));
      else
         dest = {$urandom, $urandom};
      for (int i = 0; i < 2 * ADDR_BYTES + plen && i < cut_at; i++) begin
         if (i == err_at) begin
            send_event(live_event(1'b0, 1'b1, 8'($urandom_range(0, 255))));
            repeat ($urandom_range(0, 3))
               send_event(live_event(1'b0, 1'($urandom_range(0, 1)),
                                     8'($urandom_range(0, 255))));
            break;
         end
         if (i >= ADDR_BYTES && i < 2 * ADDR_BYTES)
            b = dest[(i - ADDR_BYTES)*8 +: 8];
         else
            b = 8'($urandom_range(0, 255));
         send_event(live_event(1'b0, 1'b0, b));
      end
      if (close)
         send_gap();
   endtask

   task automatic random_frame();
      int sel;
      int plen;
      sel  = $urandom_range(0, 99);
      plen = ($urandom_range(0, 3) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
      if (sel < 60) begin
         play_frame(plen, -1, 1 << 30, 1'b1);
      end else if (sel < 75) begin
         play_frame(plen, $urandom_range(0, 2 * ADDR_BYTES + plen - 1), 1 << 30, 1'b1);
      end else if (sel < 85) begin
         play_frame(plen, -1, $urandom_range(1, 2 * ADDR_BYTES - 1), 1'b1);
      end else if (sel < 95) begin
         repeat ($urandom_range(1, 3))
            send_event(live_event(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                  8'($urandom_range(0, 255))));
         send_gap();
      end else begin
         send_gap();
         play_frame(plen, -1, 1 << 30, 1'b1);
      end
   endtask

   initial begin : stimulus
      logic [gfdr_pkg::ADDR_W-1:0] addr;
      int                          start;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      csr_valid  = 1'b0;
      csr_data   = '0;
      drv_ev     = '0;
      repeat (6) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // directed rows at the reset address
      foreach (DIRECTED[i])
         send_event(DIRECTED[i]);
      drain();

      // random phases, each with its own address
      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0:       addr = '1;
            1:       addr = '0;
            default: addr = {$urandom, $urandom};
         endcase
         if (ph % 4 == 2)
            addr[7:0] = 8'h00;
         write_own_address(addr);
         sender_quiet = (ph % 4 == 1);
         rsp_quiet    = (ph % 4 == 1) || (ph % 4 == 3);
         if (ph == 1) begin
            // hold the receiver off while payload streams in back to back
            hold_off = LONG_HOLD;
            play_frame(30, -1, 1 << 30, 1'b1);
         end
         if (ph == 3)
            play_frame(MAX_PAY + 2, -1, 1 << 30, 1'b1);
         start = events_sent;
         while (events_sent - start < PHASE_BEATS)
            random_frame();
         // leave a frame open so the next address write lands mid-frame
         if (ph % 3 == 2)
            play_frame(8, -1, $urandom_range(ADDR_BYTES + 1, 2 * ADDR_BYTES - 1), 1'b0);
         drain();
      end

      send_gap();
      drain();
      repeat (10) @(posedge clock);
      if (mismatches == 0 && due_beats.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

@@ gap_framed_datagram_receiver_core.f @@
rtl/gfdr_pkg.sv
rtl/gfdr_parser.sv
rtl/gap_framed_datagram_receiver_core.sv
rtl/gfdr_checker.sv
tb/tb_gap_framed_datagram_receiver_core.sv
